FILE: rtl/core/maze_dfs_backtracker_top_assert.svh
// Assertion macros used by the maze generator datapath.
`ifndef MAZE_DFS_BACKTRACKER_TOP_ASSERT_SVH
`define MAZE_DFS_BACKTRACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MDFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("maze generator assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MDFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("maze generator assertion failed");

`endif

FILE: rtl/core/mdfs_pkg.sv
// Shared types and constants of the maze generator.
package mdfs_pkg;

	localparam int MODE_W   = 2;
	localparam int RND_W    = 15;
	localparam int COORD_W  = 6;
	localparam int WALLS_W  = 4;
	localparam int OPEN_W   = 3;
	localparam int CFG_W    = 7;
	localparam int CELL_W   = 5;
	localparam int CRD_W    = 9;
	localparam int SLOTS    = 5;

	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [WALLS_W-1:0] WALL_N   = 4'd8;
	localparam logic [WALLS_W-1:0] WALL_S   = 4'd4;
	localparam logic [WALLS_W-1:0] WALL_E   = 4'd2;
	localparam logic [WALLS_W-1:0] WALL_W   = 4'd1;
	localparam logic [WALLS_W-1:0] WALL_ALL = 4'd15;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_S = 2'd1;
	localparam logic [1:0] DIR_E = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	localparam logic [2:0] SLOT_CUR = 3'd0;
	localparam logic [2:0] SLOT_LAST = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SWEEP, ST_ORIGIN, ST_EXIT, ST_POP, ST_POS, ST_FETCH,
		ST_LAST, ST_PICK, ST_WR_CUR, ST_WR_NB, ST_READ, ST_DONE
	} mdfs_state_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic origin;
		logic exit_wr;
		logic pop;
		logic pos;
		logic fetch;
		logic pick;
		logic wr_cur;
		logic wr_nb;
		logic load;
	} mdfs_cmd_t;

	typedef struct packed {
		logic stack_empty;
		logic sweep_last;
		logic fetch_last;
		logic any_open;
		logic out_free;
	} mdfs_status_t;

endpackage

FILE: rtl/core/mdfs_cmd_if.sv
// Input channel: one beat carries one maze command.
interface mdfs_cmd_if import mdfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [RND_W-1:0]   random_value;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] col;

	modport source (output valid, mode, random_value, row, col, input ready);
	modport sink (input valid, mode, random_value, row, col, output ready);
endinterface

FILE: rtl/core/mdfs_rsp_if.sv
// Output channel: one beat carries the result of one command.
interface mdfs_rsp_if import mdfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WALLS_W-1:0] walls;
	logic               visited;
	logic               finished;
	logic [COORD_W-1:0] cur_row;
	logic [COORD_W-1:0] cur_col;
	logic               carved;
	logic [OPEN_W-1:0]  open_neighbors;

	modport source (output valid, walls, visited, finished, cur_row, cur_col, carved,
		open_neighbors, input ready);
	modport sink (input valid, walls, visited, finished, cur_row, cur_col, carved,
		open_neighbors, output ready);
endinterface

FILE: rtl/core/maze_dfs_backtracker_top.sv
// Maze generator top level: randomized depth-first walk over a cell grid.
//
// Channels: cmd (sink) takes one command per beat: mode 0 starts a new maze,
// mode 1 does one walk step with random_value, mode 2 reads cell (row, col),
// mode 3 does nothing. rsp (source) gives exactly one result beat per command.
// cfg_we/cfg_index/cfg_data write row_count (index 0) or col_count (index 1);
// the user must write them only while no command is in flight (not enforced).
// Commands are handled one at a time by a sequencer over two RAMs (cells and
// walk stack), each read once per cycle with registered data.
// A start sweeps all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells, one per cycle,
// then writes the entry and exit cells.
// The result sits in an output register; a new command is taken while it
// waits, and a stalled rsp holds the next command only in its final DONE state.
// Reset clears the stack depth and sets both sizes to 8; cell contents stay
// undefined until the first start command.
module maze_dfs_backtracker_top import mdfs_pkg::*; #(
	parameter int MAX_ROWS     = 64,
	parameter int MAX_COLS     = 64,
	parameter int RANDOM_RANGE = 32768
) (
	input  logic             clk,
	input  logic             arst_n,
	mdfs_cmd_if.sink         cmd,
	mdfs_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	mdfs_cmd_t    ctl_cmd;
	mdfs_status_t ctl_status;

	mdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_mode  (cmd.mode),
		.in_ready (cmd.ready),
		.status   (ctl_status),
		.cmd      (ctl_cmd)
	);

	mdfs_datapath #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_COLS     (MAX_COLS),
		.RANDOM_RANGE (RANDOM_RANGE)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_mode            (cmd.mode),
		.in_random_value    (cmd.random_value),
		.in_row             (cmd.row),
		.in_col             (cmd.col),
		.cmd                (ctl_cmd),
		.status             (ctl_status),
		.out_ready          (rsp.ready),
		.out_valid          (rsp.valid),
		.out_walls          (rsp.walls),
		.out_visited        (rsp.visited),
		.out_finished       (rsp.finished),
		.out_cur_row        (rsp.cur_row),
		.out_cur_col        (rsp.cur_col),
		.out_carved         (rsp.carved),
		.out_open_neighbors (rsp.open_neighbors)
	);
endmodule

FILE: rtl/core/mdfs_ram.sv
// Generic single-port-write RAM with one registered read port.
module mdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/mdfs_ctrl.sv
// Sequencer of the maze generator: walks each command through its steps.
module mdfs_ctrl import mdfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MODE_W-1:0] in_mode,
	output logic              in_ready,
	input  mdfs_status_t      status,
	output mdfs_cmd_t         cmd
);
	mdfs_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_mode)
						MODE_START: state_d = ST_SWEEP;
						MODE_STEP:  state_d = status.stack_empty ? ST_DONE : ST_POP;
						MODE_READ:  state_d = ST_READ;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SWEEP:  if (status.sweep_last) state_d = ST_ORIGIN;
			ST_ORIGIN: state_d = ST_EXIT;
			ST_EXIT:   state_d = ST_DONE;
			ST_POP:    state_d = ST_POS;
			ST_POS:    state_d = ST_FETCH;
			ST_FETCH:  if (status.fetch_last) state_d = ST_LAST;
			ST_LAST:   state_d = ST_PICK;
			ST_PICK:   state_d = status.any_open ? ST_WR_CUR : ST_DONE;
			ST_WR_CUR: state_d = ST_WR_NB;
			ST_WR_NB:  state_d = ST_DONE;
			ST_READ:   state_d = ST_DONE;
			ST_DONE:   if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE:   cmd.accept = in_valid;
			ST_SWEEP:  cmd.sweep = 1'b1;
			ST_ORIGIN: cmd.origin = 1'b1;
			ST_EXIT:   cmd.exit_wr = 1'b1;
			ST_POP:    cmd.pop = 1'b1;
			ST_POS:    cmd.pos = 1'b1;
			ST_FETCH:  cmd.fetch = 1'b1;
			ST_PICK:   cmd.pick = 1'b1;
			ST_WR_CUR: cmd.wr_cur = 1'b1;
			ST_WR_NB:  cmd.wr_nb = 1'b1;
			ST_DONE:   cmd.load = status.out_free;
			default:   cmd = '0;
		endcase
	end
endmodule

FILE: rtl/core/mdfs_datapath.sv
// Datapath of the maze generator: cell store, walk stack, neighbor choice, result register.
`include "maze_dfs_backtracker_top_assert.svh"
module mdfs_datapath import mdfs_pkg::*; #(
	parameter int MAX_ROWS     = 64,
	parameter int MAX_COLS     = 64,
	parameter int RANDOM_RANGE = 32768
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [MODE_W-1:0]  in_mode,
	input  logic [RND_W-1:0]   in_random_value,
	input  logic [COORD_W-1:0] in_row,
	input  logic [COORD_W-1:0] in_col,
	input  mdfs_cmd_t          cmd,
	output mdfs_status_t       status,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [WALLS_W-1:0] out_walls,
	output logic               out_visited,
	output logic               out_finished,
	output logic [COORD_W-1:0] out_cur_row,
	output logic [COORD_W-1:0] out_cur_col,
	output logic               out_carved,
	output logic [OPEN_W-1:0]  out_open_neighbors
);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int CELLS = 1 << AW;
	localparam int TOTAL = MAX_ROWS * MAX_COLS;
	localparam int SAW   = $clog2(TOTAL);
	localparam int DW    = $clog2(TOTAL + 1);
	localparam int SPAN2 = RANDOM_RANGE / 2;
	localparam int SPAN3 = RANDOM_RANGE / 3;
	localparam int SPAN4 = RANDOM_RANGE / 4;
	localparam int TH_W  = 18;

	// Configuration and latched command.
	logic [CFG_W-1:0]  nr_q, nc_q;
	logic [MODE_W-1:0] mode_q;
	logic [RND_W-1:0]  rnd_q;
	logic [AW-1:0]     rd_addr_q;
	logic              rd_in_q;
	logic [CRD_W-1:0]  row9, col9;

	assign row9 = CRD_W'(in_row);
	assign col9 = CRD_W'(in_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nr_q <= CFG_W'(8);
			nc_q <= CFG_W'(8);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) nr_q <= cfg_data;
			if (cfg_index == REG_COLS) nc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q    <= in_mode;
			rnd_q     <= in_random_value;
			rd_addr_q <= {row9[RW-1:0], col9[CW-1:0]};
			rd_in_q   <= (row9 < CRD_W'(MAX_ROWS)) && (col9 < CRD_W'(MAX_COLS));
		end
	end

	// Effective grid size, clamped to 1..MAX.
	logic [CRD_W-1:0] nr_eff, nc_eff;
	always_comb begin
		if (nr_q == '0) nr_eff = CRD_W'(1);
		else if (CRD_W'(nr_q) > CRD_W'(MAX_ROWS)) nr_eff = CRD_W'(MAX_ROWS);
		else nr_eff = CRD_W'(nr_q);
		if (nc_q == '0) nc_eff = CRD_W'(1);
		else if (CRD_W'(nc_q) > CRD_W'(MAX_COLS)) nc_eff = CRD_W'(MAX_COLS);
		else nc_eff = CRD_W'(nc_q);
	end

	// Sweep and fetch counters.
	logic [AW-1:0] sweep_q;
	logic [2:0]    fetch_idx_q;
	logic          cap_v_s1;
	logic [2:0]    cap_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_v_s1 <= 1'b0;
		end else begin
			cap_v_s1 <= cmd.fetch;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) sweep_q <= '0;
		else if (cmd.sweep) sweep_q <= sweep_q + AW'(1);
		if (cmd.pos) fetch_idx_q <= SLOT_CUR;
		else if (cmd.fetch) fetch_idx_q <= fetch_idx_q + 3'd1;
		cap_idx_s1 <= fetch_idx_q;
	end

	// Walk stack and current position.
	logic [DW-1:0]    depth_q;
	logic [CRD_W-1:0] r_q, c_q;
	logic             step_q;
	logic             stk_we;
	logic [SAW-1:0]   stk_waddr, stk_raddr;
	logic [AW-1:0]    stk_wdata, stk_rdata;

	// Cell store ports.
	logic              cell_we;
	logic [AW-1:0]     cell_waddr, cell_raddr;
	logic [CELL_W-1:0] cell_wdata, cell_rdata;

	// Fetched cells: current, then north, south, east, west.
	logic [CELL_W-1:0] slot_q [SLOTS];

	always_ff @(posedge clk) begin
		if (cap_v_s1) slot_q[cap_idx_s1] <= cell_rdata;
		if (cmd.pos) begin
			r_q <= CRD_W'(stk_rdata[AW-1:CW]);
			c_q <= CRD_W'(stk_rdata[CW-1:0]);
		end
	end

	// Neighbor scan: which directions are open, how many, which one is taken.
	logic [3:0]        open_v;
	logic [OPEN_W-1:0] n_cnt;
	logic [1:0]        pick, dir_d, seen_cnt;
	logic              rin, cin;

	always_comb begin
		rin = r_q < nr_eff;
		cin = c_q < nc_eff;
		open_v[DIR_N] = (r_q != '0) && ((r_q - CRD_W'(1)) < nr_eff) && cin && !slot_q[1][4];
		open_v[DIR_S] = ((r_q + CRD_W'(1)) < nr_eff) && cin && !slot_q[2][4];
		open_v[DIR_E] = ((c_q + CRD_W'(1)) < nc_eff) && rin && !slot_q[3][4];
		open_v[DIR_W] = (c_q != '0) && ((c_q - CRD_W'(1)) < nc_eff) && rin && !slot_q[4][4];
		n_cnt = OPEN_W'($countones(open_v));
	end

	// Quotient of the random word by the span, capped at the last open direction, found by threshold compares.
	logic [TH_W-1:0] rnd18;
	assign rnd18 = TH_W'(rnd_q);

	always_comb begin
		unique case (n_cnt)
			3'd2: pick = (rnd18 >= TH_W'(SPAN2)) ? 2'd1 : 2'd0;
			3'd3: begin
				if (rnd18 >= TH_W'(2 * SPAN3)) pick = 2'd2;
				else if (rnd18 >= TH_W'(SPAN3)) pick = 2'd1;
				else pick = 2'd0;
			end
			3'd4: begin
				if (rnd18 >= TH_W'(3 * SPAN4)) pick = 2'd3;
				else if (rnd18 >= TH_W'(2 * SPAN4)) pick = 2'd2;
				else if (rnd18 >= TH_W'(SPAN4)) pick = 2'd1;
				else pick = 2'd0;
			end
			default: pick = 2'd0;
		endcase
	end

	// The pick-th open direction in north, south, east, west order.
	always_comb begin
		dir_d = DIR_N;
		seen_cnt = 2'd0;
		for (int d = 0; d < 4; d++) begin
			if (open_v[d]) begin
				if (seen_cnt == pick) dir_d = 2'(d);
				seen_cnt = seen_cnt + 2'd1;
			end
		end
	end

	logic [1:0]        dir_q;
	logic [OPEN_W-1:0] n_q;
	logic [3:0]        open_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q    <= '0;
			step_q <= 1'b0;
		end else begin
			if (cmd.pick) begin
				n_q    <= n_cnt;
				dir_q  <= dir_d;
				open_q <= open_v;
			end
			if (cmd.pop) step_q <= 1'b1;
		end
	end

	// Chosen neighbor and the walls on both sides of the passage.
	logic [CRD_W-1:0]   nb_r, nb_c;
	logic [WALLS_W-1:0] mine, theirs;
	logic [CELL_W-1:0]  nb_cell;

	always_comb begin
		nb_r = r_q;
		nb_c = c_q;
		unique case (dir_q)
			DIR_N: begin
				nb_r = r_q - CRD_W'(1); mine = WALL_N; theirs = WALL_S; nb_cell = slot_q[1];
			end
			DIR_S: begin
				nb_r = r_q + CRD_W'(1); mine = WALL_S; theirs = WALL_N; nb_cell = slot_q[2];
			end
			DIR_E: begin
				nb_c = c_q + CRD_W'(1); mine = WALL_E; theirs = WALL_W; nb_cell = slot_q[3];
			end
			default: begin
				nb_c = c_q - CRD_W'(1); mine = WALL_W; theirs = WALL_E; nb_cell = slot_q[4];
			end
		endcase
	end

	// Cell store read address: neighbor fetch, otherwise the read item's cell.
	logic [CRD_W-1:0] f_r, f_c;
	always_comb begin
		f_r = r_q;
		f_c = c_q;
		unique case (fetch_idx_q)
			3'd1:    f_r = r_q - CRD_W'(1);
			3'd2:    f_r = r_q + CRD_W'(1);
			3'd3:    f_c = c_q + CRD_W'(1);
			3'd4:    f_c = c_q - CRD_W'(1);
			default: f_r = r_q;
		endcase
		cell_raddr = cmd.fetch ? {f_r[RW-1:0], f_c[CW-1:0]} : rd_addr_q;
	end

	// Cell store writes: sweep, entry, exit and carving.
	logic [CRD_W-1:0] ex_r, ex_c;
	assign ex_r = nr_eff - CRD_W'(1);
	assign ex_c = nc_eff - CRD_W'(1);

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = sweep_q;
		cell_wdata = {1'b0, WALL_ALL};
		if (cmd.sweep) begin
			cell_we = 1'b1;
		end else if (cmd.origin) begin
			cell_we    = 1'b1;
			cell_waddr = '0;
			cell_wdata = {1'b1, WALL_ALL & ~WALL_N};
		end else if (cmd.exit_wr) begin
			cell_we    = 1'b1;
			cell_waddr = {ex_r[RW-1:0], ex_c[CW-1:0]};
			if (ex_r == '0 && ex_c == '0) cell_wdata = {1'b1, WALL_ALL & ~WALL_N & ~WALL_S};
			else cell_wdata = {1'b0, WALL_ALL & ~WALL_S};
		end else if (cmd.wr_cur) begin
			cell_we    = 1'b1;
			cell_waddr = {r_q[RW-1:0], c_q[CW-1:0]};
			cell_wdata = {1'b1, slot_q[0][WALLS_W-1:0] & ~mine};
		end else if (cmd.wr_nb) begin
			cell_we    = 1'b1;
			cell_waddr = {nb_r[RW-1:0], nb_c[CW-1:0]};
			cell_wdata = {1'b1, nb_cell[WALLS_W-1:0] & ~theirs};
		end
	end

	// Stack pushes are dropped once the stack is full.
	logic room;
	assign room = depth_q < DW'(TOTAL);

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = SAW'(depth_q);
		stk_wdata = {r_q[RW-1:0], c_q[CW-1:0]};
		stk_raddr = SAW'(depth_q - DW'(1));
		if (cmd.origin) begin
			stk_we    = 1'b1;
			stk_waddr = '0;
			stk_wdata = '0;
		end else if (cmd.wr_cur) begin
			stk_we = room;
		end else if (cmd.wr_nb) begin
			stk_we    = room;
			stk_wdata = {nb_r[RW-1:0], nb_c[CW-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.origin) begin
			depth_q <= DW'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_q - DW'(1);
		end else if ((cmd.wr_cur || cmd.wr_nb) && room) begin
			depth_q <= depth_q + DW'(1);
		end
	end

	mdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cells (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	mdfs_ram #(.WIDTH(AW), .DEPTH(TOTAL)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Result register.
	logic ov_q;
	logic is_read;
	assign is_read = (mode_q == MODE_READ) && rd_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_walls          <= is_read ? cell_rdata[WALLS_W-1:0] : '0;
			out_visited        <= is_read ? cell_rdata[4] : 1'b0;
			out_finished       <= (depth_q == '0);
			out_cur_row        <= step_q ? r_q[COORD_W-1:0] : '0;
			out_cur_col        <= step_q ? c_q[COORD_W-1:0] : '0;
			out_carved         <= (n_q != '0);
			out_open_neighbors <= n_q;
		end
	end

	assign out_valid = ov_q;

	// Status to the sequencer; the open test looks at the live scan.
	always_comb begin
		status.stack_empty = (depth_q == '0);
		status.sweep_last  = (sweep_q == AW'(CELLS - 1));
		status.fetch_last  = (fetch_idx_q == SLOT_LAST);
		status.any_open    = (n_cnt != '0);
		status.out_free    = !ov_q || out_ready;
	end

	`MDFS_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DW'(TOTAL))
	`MDFS_ASSERT_IMP(a_carve_needs_open, cmd.wr_cur || cmd.wr_nb, n_q != '0)
	`MDFS_ASSERT_IMP(a_dir_is_open, cmd.wr_nb, open_q[dir_q])
	`MDFS_ASSERT_NEXT(a_load_shows, cmd.load, ov_q)
endmodule

FILE: test/maze_dfs_backtracker_tb_pkg.sv
// Item and result types used by the maze generator testbench.
package maze_dfs_backtracker_tb_pkg;
	import mdfs_pkg::*;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [RND_W-1:0]   random_value;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} maze_cmd_t;

	typedef struct packed {
		logic [WALLS_W-1:0] walls;
		logic               visited;
		logic               finished;
		logic [COORD_W-1:0] cur_row;
		logic [COORD_W-1:0] cur_col;
		logic               carved;
		logic [OPEN_W-1:0]  open_neighbors;
	} maze_rsp_t;

	// A pending item is either a command or a size register write.
	typedef struct packed {
		logic               is_cfg;
		logic               cfg_index;
		logic [CFG_W-1:0]   cfg_data;
		maze_cmd_t          cmd;
	} maze_job_t;
endpackage

FILE: test/maze_dfs_backtracker_top_tb.sv
// Self-checking testbench of the maze generator top level.
module maze_dfs_backtracker_top_tb;
	import mdfs_pkg::*;
	import maze_dfs_backtracker_tb_pkg::*;

	localparam int NR = 64;
	localparam int NC = 64;
	localparam int CELLS = NR * NC;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	mdfs_cmd_if cmd_ch ();
	mdfs_rsp_if rsp_ch ();

	maze_dfs_backtracker_top DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .rsp(rsp_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state of the maze.
	logic [4:0] maze_cells [CELLS];
	logic [5:0] trail_row [CELLS];
	logic [5:0] trail_col [CELLS];
	int unsigned trail_depth = 0;
	logic [CFG_W-1:0] rows_reg = CFG_W'(8);
	logic [CFG_W-1:0] cols_reg = CFG_W'(8);

	maze_job_t pending_jobs[$];
	maze_rsp_t expected_rsps[$];
	int errors = 0;
	bit stim_done = 0;
	bit hold_long = 0;

	function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > 64) return 64;
		return 32'(v);
	endfunction

	function automatic void trail_push(int unsigned r, int unsigned c);
		if (trail_depth >= CELLS) return;
		trail_row[trail_depth] = 6'(r);
		trail_col[trail_depth] = 6'(c);
		trail_depth++;
	endfunction

	// Computes the result of one command and updates the predicted maze.
	function automatic maze_rsp_t walk_predict(maze_cmd_t c);
		maze_rsp_t o;
		int unsigned nrow, ncol, r, k, n, pick, span, idx;
		int unsigned nbr[4], nbc[4];
		logic [WALLS_W-1:0] mine[4], theirs[4];
		o = '0;
		nrow = eff_dim(rows_reg);
		ncol = eff_dim(cols_reg);
		case (c.mode)
			MODE_START: begin
				for (int i = 0; i < CELLS; i++) maze_cells[i] = {1'b0, WALL_ALL};
				maze_cells[0] = {1'b1, WALL_ALL & ~WALL_N};
				idx = (nrow - 1) * NC + ncol - 1;
				maze_cells[idx][3:0] = maze_cells[idx][3:0] & ~WALL_S;
				trail_depth = 0;
				trail_push(0, 0);
			end
			MODE_STEP: begin
				if (trail_depth > 0) begin
					trail_depth--;
					r = trail_row[trail_depth];
					k = trail_col[trail_depth];
					n = 0;
					if (r >= 1 && r - 1 < nrow && k < ncol && !maze_cells[(r-1)*NC+k][4]) begin
						nbr[n] = r - 1; nbc[n] = k; mine[n] = WALL_N; theirs[n] = WALL_S; n++;
					end
					if (r + 1 < nrow && k < ncol && !maze_cells[(r+1)*NC+k][4]) begin
						nbr[n] = r + 1; nbc[n] = k; mine[n] = WALL_S; theirs[n] = WALL_N; n++;
					end
					if (k + 1 < ncol && r < nrow && !maze_cells[r*NC+k+1][4]) begin
						nbr[n] = r; nbc[n] = k + 1; mine[n] = WALL_E; theirs[n] = WALL_W; n++;
					end
					if (k >= 1 && k - 1 < ncol && r < nrow && !maze_cells[r*NC+k-1][4]) begin
						nbr[n] = r; nbc[n] = k - 1; mine[n] = WALL_W; theirs[n] = WALL_E; n++;
					end
					o.cur_row = 6'(r);
					o.cur_col = 6'(k);
					o.open_neighbors = 3'(n);
					if (n > 0) begin
						trail_push(r, k);
						span = 32768 / n;
						pick = c.random_value / span;
						if (pick > n - 1) pick = n - 1;
						idx = r * NC + k;
						maze_cells[idx] = {1'b1, maze_cells[idx][3:0] & ~mine[pick]};
						idx = nbr[pick] * NC + nbc[pick];
						maze_cells[idx] = {1'b1, maze_cells[idx][3:0] & ~theirs[pick]};
						trail_push(nbr[pick], nbc[pick]);
						o.carved = 1'b1;
					end
				end
			end
			MODE_READ: begin
				idx = c.row * NC + c.col;
				o.walls = maze_cells[idx][3:0];
				o.visited = maze_cells[idx][4];
			end
			default: ;
		endcase
		o.finished = (trail_depth == 0);
		return o;
	endfunction

	function automatic maze_job_t mk_cmd(logic [MODE_W-1:0] m, int unsigned rv,
			int unsigned r, int unsigned c);
		maze_job_t j;
		j = '0;
		j.cmd.mode = m;
		j.cmd.random_value = RND_W'(rv);
		j.cmd.row = COORD_W'(r);
		j.cmd.col = COORD_W'(c);
		return j;
	endfunction

	function automatic maze_job_t mk_cfg(logic idx, int unsigned v);
		maze_job_t j;
		j = '0;
		j.is_cfg = 1'b1;
		j.cfg_index = idx;
		j.cfg_data = CFG_W'(v);
		return j;
	endfunction

	// Appends one item to the pending queue.
	function automatic void add_job(maze_job_t j);
		pending_jobs.insert(pending_jobs.size(), j);
	endfunction

	// Random read inside the full store.
	function automatic maze_job_t rnd_read();
		return mk_cmd(MODE_READ, $urandom_range(32767), $urandom_range(63), $urandom_range(63));
	endfunction

	// Fills the item queue: directed part, then maze phases of varying size.
	initial begin
		int unsigned sizes[8][2];
		int unsigned rr, cc, steps;
		sizes = '{'{1, 1}, '{64, 64}, '{0, 127}, '{2, 3},
			'{5, 1}, '{1, 6}, '{7, 4}, '{100, 2}};
		// Directed: start at reset size, every mode and random extremes.
		add_job(mk_cmd(MODE_NOP, 32767, 63, 63));
		add_job(mk_cmd(MODE_STEP, 0, 0, 0));
		add_job(mk_cmd(MODE_START, 0, 0, 0));
		add_job(mk_cmd(MODE_READ, 0, 0, 0));
		add_job(mk_cmd(MODE_READ, 0, 7, 7));
		add_job(mk_cmd(MODE_STEP, 32767, 0, 0));
		add_job(mk_cmd(MODE_STEP, 0, 63, 63));
		add_job(mk_cmd(MODE_STEP, 16384, 0, 0));
		add_job(mk_cmd(MODE_READ, 32767, 63, 63));
		add_job(mk_cmd(MODE_READ, 0, 0, 1));
		add_job(mk_cmd(MODE_NOP, 0, 0, 0));
		// Phases: sizes include the one-cell grid, full grid and out-of-range values.
		for (int p = 0; p < 8; p++) begin
			add_job(mk_cfg(REG_ROWS, sizes[p][0]));
			add_job(mk_cfg(REG_COLS, sizes[p][1]));
			add_job(mk_cmd(MODE_START, $urandom_range(32767), 0, 0));
			rr = eff_dim(CFG_W'(sizes[p][0]));
			cc = eff_dim(CFG_W'(sizes[p][1]));
			steps = (rr * cc > 60) ? 280 : 2 * rr * cc + 3;
			for (int s = 0; s < steps; s++) begin
				if ($urandom_range(5) == 0) add_job(rnd_read());
				else if ($urandom_range(30) == 0)
					add_job(mk_cmd(MODE_NOP, $urandom_range(32767),
						$urandom_range(63), $urandom_range(63)));
				else add_job(mk_cmd(MODE_STEP, $urandom_range(32767),
					$urandom_range(63), $urandom_range(63)));
			end
			add_job(mk_cmd(MODE_READ, 0, rr - 1, cc - 1));
			// Shrink the grid in the middle of a walk.
			if (p == 1) begin
				add_job(mk_cfg(REG_ROWS, 3));
				add_job(mk_cfg(REG_COLS, 3));
				for (int s = 0; s < 40; s++)
					add_job(mk_cmd(MODE_STEP, $urandom_range(32767), 0, 0));
			end
		end
		// Full walk of a medium grid after a resize, then many reads.
		add_job(mk_cfg(REG_ROWS, 6));
		add_job(mk_cfg(REG_COLS, 6));
		add_job(mk_cmd(MODE_START, 0, 0, 0));
		for (int s = 0; s < 75; s++)
			add_job(mk_cmd(MODE_STEP, $urandom_range(32767), 0, 0));
		for (int s = 0; s < 60; s++) add_job(rnd_read());
	end

	// Driver: bursts with random gaps; size writes only while the block is idle.
	int gap_left = 0;
	int burst_left = 0;
	int drain_wait = 0;
	maze_cmd_t cur_cmd;
	bit in_took = 1'b0;
	bit cfg_fire;

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Input beat taken at the last rising edge.
	always @(posedge clk) begin
		in_took <= arst_n && cmd_ch.valid && cmd_ch.ready;
	end

	always @(negedge clk) begin
		cfg_fire = 1'b0;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.mode <= '0;
			cmd_ch.random_value <= '0;
			cmd_ch.row <= '0;
			cmd_ch.col <= '0;
		end else begin
			if (in_took) begin
				expected_rsps.insert(expected_rsps.size(), walk_predict(cur_cmd));
				void'(pending_jobs.pop_front());
			end
			if (cmd_ch.valid && !in_took) begin
				// Hold the offered beat.
			end else if (pending_jobs.size() == 0) begin
				cmd_ch.valid <= 1'b0;
				stim_done <= 1'b1;
			end else if (pending_jobs[0].is_cfg) begin
				cmd_ch.valid <= 1'b0;
				if (expected_rsps.size() != 0 || in_took) begin
					drain_wait <= 0;
				end else if (drain_wait < 20) begin
					drain_wait <= drain_wait + 1;
				end else begin
					cfg_fire = 1'b1;
					cfg_index <= pending_jobs[0].cfg_index;
					cfg_data <= pending_jobs[0].cfg_data;
					if (pending_jobs[0].cfg_index == REG_ROWS) rows_reg = pending_jobs[0].cfg_data;
					else cols_reg = pending_jobs[0].cfg_data;
					void'(pending_jobs.pop_front());
					drain_wait <= 0;
				end
			end else if (gap_left > 0) begin
				cmd_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else begin
				cur_cmd = pending_jobs[0].cmd;
				cmd_ch.valid <= 1'b1;
				cmd_ch.mode <= cur_cmd.mode;
				cmd_ch.random_value <= cur_cmd.random_value;
				cmd_ch.row <= cur_cmd.row;
				cmd_ch.col <= cur_cmd.col;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(40);
					gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
				end
			end
		end
		cfg_we <= cfg_fire;
	end

	// Receiver stall pattern, with one long hold-off to back up the input.
	int stall_phase = 0;
	int hold_cnt = 0;
	int rsp_seen = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (rsp_seen == 300 && hold_cnt < 400) begin
			hold_cnt <= hold_cnt + 1;
			rsp_ch.ready <= 1'b0;
		end else if ((stall_phase / 200) % 2 == 0) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ((stall_phase % 7) < 3) || ($urandom_range(1) == 1);
		end
	end

	// Monitor: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		maze_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_seen <= rsp_seen + 1;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_ch.walls !== want.walls) begin
					$error("walls: expected %0d, got %0d", want.walls, rsp_ch.walls);
					errors++;
				end
				if (rsp_ch.visited !== want.visited) begin
					$error("visited: expected %0d, got %0d", want.visited, rsp_ch.visited);
					errors++;
				end
				if (rsp_ch.finished !== want.finished) begin
					$error("finished: expected %0d, got %0d", want.finished, rsp_ch.finished);
					errors++;
				end
				if (rsp_ch.cur_row !== want.cur_row) begin
					$error("cur_row: expected %0d, got %0d", want.cur_row, rsp_ch.cur_row);
					errors++;
				end
				if (rsp_ch.cur_col !== want.cur_col) begin
					$error("cur_col: expected %0d, got %0d", want.cur_col, rsp_ch.cur_col);
					errors++;
				end
				if (rsp_ch.carved !== want.carved) begin
					$error("carved: expected %0d, got %0d", want.carved, rsp_ch.carved);
					errors++;
				end
				if (rsp_ch.open_neighbors !== want.open_neighbors) begin
					$error("open_neighbors: expected %0d, got %0d", want.open_neighbors,
						rsp_ch.open_neighbors);
					errors++;
				end
			end
		end
	end

	// End of run: drain, settle, then report.
	initial begin
		wait (stim_done);
		wait (expected_rsps.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("maze_dfs_backtracker_top_tb: PASS");
		end else begin
			$display("maze_dfs_backtracker_top_tb: FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("maze_dfs_backtracker_top_tb: FAIL");
		$finish;
	end
endmodule
